// File: rtl/sgr_pkg.sv
// sgr_pkg: shared types and constants of the sibilance gain reducer
// holds payload structs, configuration struct, controller states and datapath commands
// no dependencies
package sgr_pkg;

    // sample format and fixed-point constants
    localparam int SAMPLE_BITS = 24;
    localparam int GAIN_BITS   = 24;
    localparam int COEFF_BITS  = 24;
    localparam int RECIP_BITS  = 32;
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [GAIN_BITS-1:0]  ONE_Q23 = 24'd8388608;
    localparam logic [COEFF_BITS-1:0] W_NEW   = 24'd5033165;
    localparam logic [COEFF_BITS-1:0] W_OLD   = 24'd11744051;

    // multiplier and accumulator widths
    localparam int OPA_BITS  = 25;
    localparam int OPB_BITS  = 33;
    localparam int PROD_BITS = OPA_BITS + OPB_BITS;
    localparam int ACC_BITS  = PROD_BITS + 2;

    // register reset values
    localparam logic [COEFF_BITS-1:0] ATTACK_RESET    = 24'd16431300;
    localparam logic [COEFF_BITS-1:0] RELEASE_RESET   = 24'd16770226;
    localparam logic [GAIN_BITS-1:0]  THRESHOLD_RESET = 24'd838861;
    localparam logic [RECIP_BITS-1:0] RECIP_RESET     = 32'd10485760;
    localparam logic [GAIN_BITS-1:0]  RANGE_RESET     = 24'd4194304;

    // register indexes
    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_ATTACK    = 3'd0,
        REG_RELEASE   = 3'd1,
        REG_THRESHOLD = 3'd2,
        REG_RECIP     = 3'd3,
        REG_RANGE     = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [COEFF_BITS-1:0] attack_coeff;
        logic [COEFF_BITS-1:0] release_coeff;
        logic [GAIN_BITS-1:0]  threshold_level;
        logic [RECIP_BITS-1:0] threshold_reciprocal;
        logic [GAIN_BITS-1:0]  range_level;
    } cfg_t;

    // input and output beats
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic                          channel;
        logic                          block_start;
    } in_beat_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic [GAIN_BITS-1:0]          gain_applied;
    } out_beat_t;

    // controller states
    typedef enum logic [4:0] {
        S_IDLE,
        S_SM0, S_SM1, S_SM2, S_SM3,
        S_EN0, S_EN1, S_EN2, S_EN3, S_EN4,
        S_GN0, S_GN1, S_GN2, S_GN3, S_GN4, S_GN5, S_GN6,
        S_OUT0, S_OUT1, S_OUT2
    } state_t;

    // multiplier operand selection
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_SM_NEW,
        MUL_SM_OLD,
        MUL_ENV_OLD,
        MUL_ENV_NEW,
        MUL_RATIO,
        MUL_GAIN,
        MUL_OUT
    } mul_sel_t;

    // accumulator operation
    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD_R23,
        ACC_LOAD_R22,
        ACC_LOAD_R19,
        ACC_ADD
    } acc_op_t;

    // result capture
    typedef enum logic [2:0] {
        LATCH_NONE,
        LATCH_SMOOTH,
        LATCH_COEFF,
        LATCH_ENV,
        LATCH_DIFF,
        LATCH_RATIO,
        LATCH_GAIN,
        LATCH_OUT
    } latch_t;

    typedef struct packed {
        logic     capture;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        latch_t   latch;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

// File: rtl/sgr_cfg_regs.sv
// sgr_cfg_regs: configuration register file of the sibilance gain reducer
// depends on sgr_pkg
module sgr_cfg_regs (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [sgr_pkg::CFG_ADDR_BITS-1:0]     cfg_addr,
    input  logic [sgr_pkg::CFG_DATA_BITS-1:0]     cfg_wdata,
    output sgr_pkg::cfg_t                         cfg
);
    import sgr_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // decode the write; unused indexes leave everything as is
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_ATTACK:    cfg_next.attack_coeff         = cfg_wdata[COEFF_BITS-1:0];
                REG_RELEASE:   cfg_next.release_coeff        = cfg_wdata[COEFF_BITS-1:0];
                REG_THRESHOLD: cfg_next.threshold_level      = cfg_wdata[GAIN_BITS-1:0];
                REG_RECIP:     cfg_next.threshold_reciprocal = cfg_wdata[RECIP_BITS-1:0];
                REG_RANGE:     cfg_next.range_level          = cfg_wdata[GAIN_BITS-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.attack_coeff         <= ATTACK_RESET;
            cfg_reg.release_coeff        <= RELEASE_RESET;
            cfg_reg.threshold_level      <= THRESHOLD_RESET;
            cfg_reg.threshold_reciprocal <= RECIP_RESET;
            cfg_reg.range_level          <= RANGE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/sgr_ctrl.sv
// sgr_ctrl: sequencing state machine of the sibilance gain reducer
// steps the shared multiplier and accumulator; depends on sgr_pkg
module sgr_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  sgr_pkg::dp_status_t   status,
    output sgr_pkg::dp_cmd_t      cmd
);
    import sgr_pkg::*;

    state_t state_reg;
    state_t state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_SM0;
            S_SM0:   state_next = S_SM1;
            S_SM1:   state_next = S_SM2;
            S_SM2:   state_next = S_SM3;
            S_SM3:   state_next = S_EN0;
            S_EN0:   state_next = S_EN1;
            S_EN1:   state_next = S_EN2;
            S_EN2:   state_next = S_EN3;
            S_EN3:   state_next = S_EN4;
            S_EN4:   state_next = S_GN0;
            S_GN0:   state_next = S_GN1;
            S_GN1:   state_next = S_GN2;
            S_GN2:   state_next = S_GN3;
            S_GN3:   state_next = S_GN4;
            S_GN4:   state_next = S_GN5;
            S_GN5:   state_next = S_GN6;
            S_GN6:   state_next = S_OUT0;
            S_OUT0:  state_next = S_OUT1;
            S_OUT1:  state_next = S_OUT2;
            S_OUT2:  if (status.out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // commands to the datapath
    always_comb
    begin
        cmd.capture = 1'b0;
        cmd.mul_sel = MUL_NONE;
        cmd.acc_op  = ACC_HOLD;
        cmd.latch   = LATCH_NONE;
        in_stall    = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            S_SM0:   cmd.mul_sel = MUL_SM_NEW;
            S_SM1:
            begin
                cmd.mul_sel = MUL_SM_OLD;
                cmd.acc_op  = ACC_LOAD_R23;
            end
            S_SM2:   cmd.acc_op = ACC_ADD;
            S_SM3:   cmd.latch  = LATCH_SMOOTH;
            S_EN0:   cmd.latch  = LATCH_COEFF;
            S_EN1:   cmd.mul_sel = MUL_ENV_OLD;
            S_EN2:
            begin
                cmd.mul_sel = MUL_ENV_NEW;
                cmd.acc_op  = ACC_LOAD_R23;
            end
            S_EN3:   cmd.acc_op  = ACC_ADD;
            S_EN4:   cmd.latch   = LATCH_ENV;
            S_GN0:   cmd.latch   = LATCH_DIFF;
            S_GN1:   cmd.mul_sel = MUL_RATIO;
            S_GN2:   cmd.acc_op  = ACC_LOAD_R19;
            S_GN3:   cmd.latch   = LATCH_RATIO;
            S_GN4:   cmd.mul_sel = MUL_GAIN;
            S_GN5:   cmd.acc_op  = ACC_LOAD_R22;
            S_GN6:   cmd.latch   = LATCH_GAIN;
            S_OUT0:  cmd.mul_sel = MUL_OUT;
            S_OUT1:  cmd.acc_op  = ACC_LOAD_R22;
            S_OUT2:  if (status.out_free) cmd.latch = LATCH_OUT;
            default: in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/sgr_datapath.sv
// sgr_datapath: per-channel state, shared multiplier, accumulator and output register
// driven by sgr_ctrl commands; depends on sgr_pkg
module sgr_datapath #(
    parameter int CHANNEL_COUNT = 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sgr_pkg::cfg_t         cfg,
    input  sgr_pkg::dp_cmd_t      cmd,
    output sgr_pkg::dp_status_t   status,
    input  sgr_pkg::in_beat_t     in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output sgr_pkg::out_beat_t    out_data
);
    import sgr_pkg::*;

    localparam int CH_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

    // per-channel state
    logic signed [SAMPLE_BITS-1:0] smoother_reg [CHANNEL_COUNT];
    logic [GAIN_BITS-1:0]          envelope_reg [CHANNEL_COUNT];

    // captured item
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic [CH_W-1:0]               ch_reg;
    logic                          start_reg;

    // intermediate values
    logic [GAIN_BITS-1:0]   mag_reg;
    logic [COEFF_BITS-1:0]  coeff_reg;
    logic [GAIN_BITS-1:0]   env_reg;
    logic                   above_reg;
    logic [GAIN_BITS-1:0]   diff_reg;
    logic [GAIN_BITS-1:0]   ratio_reg;
    logic [GAIN_BITS-1:0]   rdiff_reg;
    logic [GAIN_BITS-1:0]   gain_reg;

    logic signed [PROD_BITS-1:0] prod_reg;
    logic signed [ACC_BITS-1:0]  acc_reg;

    out_beat_t out_reg;
    logic      out_valid_reg;

    logic signed [OPA_BITS-1:0]    op_a;
    logic signed [OPB_BITS-1:0]    op_b;
    logic signed [PROD_BITS-1:0]   prod_next;
    logic signed [ACC_BITS-1:0]    prod_ext;
    logic signed [ACC_BITS-1:0]    acc_next;
    logic signed [SAMPLE_BITS-1:0] prev_eff;
    logic [GAIN_BITS-1:0]          env_cur;
    logic signed [SAMPLE_BITS-1:0] smoothed;
    logic [GAIN_BITS-1:0]          mag;
    logic [GAIN_BITS:0]            env_sum;
    logic [GAIN_BITS-1:0]          env_new;
    logic [ACC_BITS-21:0]          ratio_wide;
    logic [GAIN_BITS:0]            reduction;
    logic [GAIN_BITS-1:0]          range_sat;
    logic [CH_W-1:0]               ch_in;

    assign ch_in    = (CHANNEL_COUNT > 1) ? CH_W'(in_data.channel) : '0;
    assign prev_eff = start_reg ? '0 : smoother_reg[ch_reg];
    assign env_cur  = envelope_reg[ch_reg];

    // operand selection for the shared multiplier
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        unique case (cmd.mul_sel)
            MUL_SM_NEW:
            begin
                op_a = OPA_BITS'(x_reg);
                op_b = {{(OPB_BITS-COEFF_BITS){1'b0}}, W_NEW};
            end
            MUL_SM_OLD:
            begin
                op_a = OPA_BITS'(prev_eff);
                op_b = {{(OPB_BITS-COEFF_BITS){1'b0}}, W_OLD};
            end
            MUL_ENV_OLD:
            begin
                op_a = {1'b0, coeff_reg};
                op_b = {{(OPB_BITS-GAIN_BITS){1'b0}}, env_cur};
            end
            MUL_ENV_NEW:
            begin
                op_a = {1'b0, mag_reg};
                op_b = {{(OPB_BITS-COEFF_BITS-1){1'b0}}, 25'h1000000 - {1'b0, coeff_reg}};
            end
            MUL_RATIO:
            begin
                op_a = {1'b0, diff_reg};
                op_b = {1'b0, cfg.threshold_reciprocal};
            end
            MUL_GAIN:
            begin
                op_a = {1'b0, rdiff_reg};
                op_b = {{(OPB_BITS-GAIN_BITS){1'b0}}, ratio_reg};
            end
            MUL_OUT:
            begin
                op_a = OPA_BITS'(x_reg);
                op_b = {{(OPB_BITS-GAIN_BITS){1'b0}}, gain_reg};
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod_next = PROD_BITS'(op_a) * PROD_BITS'(op_b);
    assign prod_ext  = ACC_BITS'(prod_reg);

    // accumulator with rounding offsets
    always_comb
    begin
        acc_next = acc_reg;
        unique case (cmd.acc_op)
            ACC_LOAD_R23: acc_next = prod_ext + (ACC_BITS'(1) <<< 23);
            ACC_LOAD_R22: acc_next = prod_ext + (ACC_BITS'(1) <<< 22);
            ACC_LOAD_R19: acc_next = prod_ext + (ACC_BITS'(1) <<< 19);
            ACC_ADD:      acc_next = acc_reg + prod_ext;
            default:      acc_next = acc_reg;
        endcase
    end

    // accumulator taps
    assign smoothed   = acc_reg[SAMPLE_BITS+23:24];
    assign mag        = smoothed[SAMPLE_BITS-1] ? GAIN_BITS'(-smoothed) : GAIN_BITS'(smoothed);
    assign env_sum    = acc_reg[GAIN_BITS+24:24];
    assign env_new    = (env_sum > {1'b0, ONE_Q23}) ? ONE_Q23 : env_sum[GAIN_BITS-1:0];
    assign ratio_wide = acc_reg[ACC_BITS-1:20];
    assign reduction  = acc_reg[GAIN_BITS+23:23];
    assign range_sat  = (cfg.range_level > ONE_Q23) ? ONE_Q23 : cfg.range_level;

    // multiplier and accumulator registers
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    // item capture and intermediate results
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            x_reg     <= in_data.sample_in;
            ch_reg    <= ch_in;
            start_reg <= in_data.block_start;
        end
        unique case (cmd.latch)
            LATCH_SMOOTH: mag_reg <= mag;
            LATCH_COEFF:  coeff_reg <= (mag_reg > env_cur) ? cfg.attack_coeff
                                                           : cfg.release_coeff;
            LATCH_ENV:    env_reg <= env_new;
            LATCH_DIFF:
            begin
                above_reg <= env_reg > cfg.threshold_level;
                diff_reg  <= env_reg - cfg.threshold_level;
            end
            LATCH_RATIO:
            begin
                ratio_reg <= (ratio_wide > (ACC_BITS-20)'(ONE_Q23)) ? ONE_Q23
                                                                    : ratio_wide[GAIN_BITS-1:0];
                rdiff_reg <= ONE_Q23 - range_sat;
            end
            LATCH_GAIN:   gain_reg <= above_reg ? ONE_Q23 - reduction[GAIN_BITS-1:0] : ONE_Q23;
            LATCH_OUT:
            begin
                out_reg.sample_out   <= acc_reg[SAMPLE_BITS+22:23];
                out_reg.gain_applied <= gain_reg;
            end
            default:      mag_reg <= mag_reg;
        endcase
    end

    // per-channel smoother and envelope
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNEL_COUNT; i++)
            begin
                smoother_reg[i] <= '0;
                envelope_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.latch == LATCH_SMOOTH)
            begin
                smoother_reg[ch_reg] <= smoothed;
            end
            if (cmd.latch == LATCH_ENV)
            begin
                envelope_reg[ch_reg] <= env_new;
            end
        end
    end

    // output beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.latch == LATCH_OUT)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.out_free = !out_valid_reg || !out_stall;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_reg;

endmodule

// File: rtl/sibilance_gain_reducer.sv
// sibilance_gain_reducer: per-channel de-esser top level
// Input channel: in_valid / in_stall / in_data (sample_in, channel, block_start).
// Output channel: out_valid / out_stall / out_data (sample_out, gain_applied).
// Configuration: cfg_wr_en writes cfg_wdata to register cfg_addr at the clock edge
//   (0 attack, 1 release, 2 threshold, 3 threshold reciprocal, 4 range);
//   other indexes are ignored. Write only while the block is idle.
// One beat is taken at a time: in_stall is low only while the sequencer is idle.
// An item runs through the smoother, envelope, gain and output steps before the next
// can be accepted; one shared 25x33 multiplier is stepped through seven products,
// each registered and then accumulated.
// The output register holds a finished beat while out_stall is high; the next
// item is still accepted and runs up to its last step, where it waits for the slot.
// Reset clears the per-channel smoother and envelope, loads the register defaults
// and leaves both channels empty. Channel numbers wrap modulo CHANNEL_COUNT.
// Depends on sgr_pkg, sgr_cfg_regs, sgr_ctrl, sgr_datapath.
module sibilance_gain_reducer #(
    parameter int CHANNEL_COUNT = 2
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  sgr_pkg::in_beat_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output sgr_pkg::out_beat_t                out_data,
    input  logic                              cfg_wr_en,
    input  logic [sgr_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [sgr_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);
    import sgr_pkg::*;

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;

    // configuration registers
    sgr_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // sequencer
    sgr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic and state
    sgr_datapath #(
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd),
        .status    (status),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
